// File: hw/rtl/mhbs_pkg.sv
// package for the multi-hart boot sequencer
// holds request, phase and action codes and the sequencer state struct
// no dependencies
package mhbs_pkg;

  // width of the hart number field
  localparam int unsigned HartW = 6;

  // request codes
  typedef enum logic [1:0] {
    REQ_ARRIVE  = 2'd0,
    REQ_POLL    = 2'd1,
    REQ_PUBLISH = 2'd2
  } req_e;

  // boot phase codes
  typedef enum logic [1:0] {
    PH_FRESH  = 2'd0,
    PH_INIT   = 2'd1,
    PH_READY  = 2'd2,
    PH_FAILED = 2'd3
  } phase_e;

  // answer codes
  typedef enum logic [2:0] {
    ACT_WAIT       = 3'd0,
    ACT_CONTINUE   = 3'd1,
    ACT_INITIALIZE = 3'd2,
    ACT_PUBLISHED  = 3'd3,
    ACT_FAULT      = 3'd4
  } action_e;

  // phase and sticky fault latch
  typedef struct packed {
    phase_e phase;
    logic   fault;
  } boot_state_t;

endpackage

// File: hw/rtl/mhbs_step.sv
// single request evaluation of the boot sequencer
// combinational: current state and arrival bits in, next state and answer out
// depends on mhbs_pkg
module mhbs_step import mhbs_pkg::*; #(
  parameter int unsigned WORKERS = 8
) (
  input  logic [1:0]         req_i,
  input  logic [HartW-1:0]   hart_i,
  input  logic               warm_i,
  input  logic               quiescent_i,
  input  boot_state_t        cur_i,
  input  logic [WORKERS-1:0] arrived_i,
  output boot_state_t        nxt_o,
  output action_e            action_o,
  output logic               set_arrival_o
);

  localparam int unsigned IdxW = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam logic [HartW:0] WorkersLim = (HartW + 1)'(WORKERS);

  logic            hart_ok;
  logic            hart_arrived;
  logic            poll_fail;
  action_e         poll_act;
  logic            fail;
  action_e         act;
  boot_state_t     nxt;

  // hart range check and arrival lookup
  assign hart_ok      = {1'b0, hart_i} < WorkersLim;
  assign hart_arrived = hart_ok && arrived_i[hart_i[IdxW-1:0]];

  // answer of a poll once the hart is known to be present
  always_comb begin
    poll_fail = 1'b0;
    poll_act  = ACT_WAIT;
    unique case (cur_i.phase)
      PH_READY:          poll_act  = ACT_CONTINUE;
      PH_FRESH, PH_INIT: poll_act  = ACT_WAIT;
      default:           poll_fail = 1'b1;
    endcase
  end

  // request decode
  always_comb begin
    nxt           = cur_i;
    act           = ACT_FAULT;
    fail          = 1'b0;
    set_arrival_o = 1'b0;
    unique case (req_i)
      REQ_ARRIVE: begin
        if (!hart_ok || warm_i || cur_i.fault || hart_arrived) begin
          fail = 1'b1;
        end else begin
          set_arrival_o = 1'b1;
          if (hart_i != '0) begin
            fail = poll_fail;
            act  = poll_act;
          end else if (cur_i.phase != PH_FRESH) begin
            fail = 1'b1;
          end else begin
            nxt.phase = PH_INIT;
            act       = ACT_INITIALIZE;
          end
        end
      end
      REQ_POLL: begin
        if (!hart_ok || cur_i.fault || !hart_arrived) begin
          fail = 1'b1;
        end else begin
          fail = poll_fail;
          act  = poll_act;
        end
      end
      REQ_PUBLISH: begin
        if (hart_i != '0 || cur_i.fault || !arrived_i[0] || !quiescent_i ||
            cur_i.phase != PH_INIT) begin
          fail = 1'b1;
        end else begin
          nxt.phase = PH_READY;
          act       = ACT_PUBLISHED;
        end
      end
      default: fail = 1'b1;
    endcase
    // any failure forces the failed phase and latches the fault
    if (fail) begin
      nxt.phase = PH_FAILED;
      nxt.fault = 1'b1;
      act       = ACT_FAULT;
    end
  end

  assign nxt_o    = nxt;
  assign action_o = act;

endmodule

// File: hw/rtl/multi_hart_boot_sequencer_unit.sv
// an accepted request is held in the input register, then moves to the output register
// throughput: one request per cycle while the output is not stalled; the phase, arrival bits
// and fault latch update in the same cycle a request moves from input to output register
// reset: asynchronous active low; phase fresh, all arrival bits clear, fault latch clear,
// both pipeline registers empty
// top level of the boot sequencer; depends on mhbs_pkg and mhbs_step
module multi_hart_boot_sequencer_unit import mhbs_pkg::*; #(
  parameter int unsigned WORKERS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       req_type_i,
  input  logic [HartW-1:0] hart_i,
  input  logic             warm_i,
  input  logic             quiescent_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       action_o,
  output logic [1:0]       boot_phase_o,
  output logic             fault_flag_o
);

  localparam int unsigned IdxW = (WORKERS > 1) ? $clog2(WORKERS) : 1;

  logic               in_accept;
  logic               advance;
  logic               s1_valid_q, s1_valid_d;
  logic [1:0]         s1_req_q;
  logic [HartW-1:0]   s1_hart_q;
  logic               s1_warm_q;
  logic               s1_quiescent_q;
  boot_state_t        state_q, state_nxt;
  logic [WORKERS-1:0] arrived_q, arrived_d;
  logic               set_arrival;
  action_e            step_act;
  logic               out_valid_q, out_valid_d;
  action_e            out_act_q;
  boot_state_t        out_state_q;

  // handshake: input register empties when the output register can take a request
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  // request evaluation
  mhbs_step #(
    .WORKERS(WORKERS)
  ) u_step (
    .req_i        (s1_req_q),
    .hart_i       (s1_hart_q),
    .warm_i       (s1_warm_q),
    .quiescent_i  (s1_quiescent_q),
    .cur_i        (state_q),
    .arrived_i    (arrived_q),
    .nxt_o        (state_nxt),
    .action_o     (step_act),
    .set_arrival_o(set_arrival)
  );

  // arrival bit update
  always_comb begin
    arrived_d = arrived_q;
    if (set_arrival) begin
      arrived_d[s1_hart_q[IdxW-1:0]] = 1'b1;
    end
  end

  // control and sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{phase: PH_FRESH, fault: 1'b0};
      arrived_q   <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q   <= state_nxt;
        arrived_q <= arrived_d;
      end
    end
  end

  // input payload register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q       <= req_type_i;
      s1_hart_q      <= hart_i;
      s1_warm_q      <= warm_i;
      s1_quiescent_q <= quiescent_i;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_act_q   <= step_act;
      out_state_q <= state_nxt;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign action_o     = out_act_q;
  assign boot_phase_o = out_state_q.phase;
  assign fault_flag_o = out_state_q.fault;

  // fault latch never clears once set
  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.fault |=> state_q.fault)
    else $error("fault latch cleared");

  // failed phase and fault flag go together
  a_failed_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((boot_phase_o == PH_FAILED) == fault_flag_o))
    else $error("failed phase and fault flag disagree");

  // a fault answer always carries the fault flag
  a_fault_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && action_o == ACT_FAULT) |-> fault_flag_o)
    else $error("fault answer without fault flag");

  // a publish answer reports the ready phase
  a_publish_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && action_o == ACT_PUBLISHED) |-> (boot_phase_o == PH_READY))
    else $error("published answer outside ready phase");

endmodule

// File: bench/tb_top.sv
// testbench for the multi-hart boot sequencer: directed boot, ready and fault requests,
// random traffic under several idling mixes, and an output hold-off that backs up the input
// depends on mhbs_pkg and multi_hart_boot_sequencer_unit
module tb_top;
  import mhbs_pkg::*;

  localparam int unsigned WORKERS = 8;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned TAIL_CYCLES = 4;
  // request code with no meaning, treated as a bad request
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    action_e act;
    phase_e  phase;
    logic    fault;
  } answer_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [1:0]       req_type_i = REQ_ARRIVE;
  logic [HartW-1:0] hart_i = '0;
  logic             warm_i = 1'b0;
  logic             quiescent_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [2:0]       action_o;
  logic [1:0]       boot_phase_o;
  logic             fault_flag_o;

  // predicted sequencer state
  phase_e      model_phase = PH_FRESH;
  logic [63:0] model_arrived = '0;
  logic        model_fault = 1'b0;

  answer_t answer_q[$];
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_left = 0;
  int      idle_cycles = 0;
  int      mismatches = 0;
  int      n_sent = 0;
  int      n_checked = 0;
  int      act_seen[8];

  multi_hart_boot_sequencer_unit #(
    .WORKERS(WORKERS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .hart_i      (hart_i),
    .warm_i      (warm_i),
    .quiescent_i (quiescent_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .action_o    (action_o),
    .boot_phase_o(boot_phase_o),
    .fault_flag_o(fault_flag_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // any failure drives the phase to failed and latches the fault
  function automatic action_e enter_failed();
    model_phase = PH_FAILED;
    model_fault = 1'b1;
    return ACT_FAULT;
  endfunction

  function automatic action_e poll_answer(logic [HartW-1:0] hart);
    if (hart >= WORKERS || model_fault || !model_arrived[hart]) return enter_failed();
    case (model_phase)
      PH_READY:          return ACT_CONTINUE;
      PH_FRESH, PH_INIT: return ACT_WAIT;
      default:           return enter_failed();
    endcase
  endfunction

  function automatic action_e arrive_answer(logic [HartW-1:0] hart, logic warm);
    if (hart >= WORKERS || warm || model_fault) return enter_failed();
    if (model_arrived[hart]) return enter_failed();
    model_arrived[hart] = 1'b1;
    // workers other than hart 0 continue as a poll
    if (hart != 0) return poll_answer(hart);
    if (model_phase != PH_FRESH) return enter_failed();
    model_phase = PH_INIT;
    return ACT_INITIALIZE;
  endfunction

  function automatic action_e publish_answer(logic [HartW-1:0] hart, logic quiet);
    if (hart != 0 || model_fault || !model_arrived[0] || !quiet) return enter_failed();
    if (model_phase != PH_INIT) return enter_failed();
    model_phase = PH_READY;
    return ACT_PUBLISHED;
  endfunction

  // predicted answer of one request, state updated in place
  function automatic answer_t boot_answer(logic [1:0] req, logic [HartW-1:0] hart,
                                          logic warm, logic quiet);
    answer_t ans;
    case (req)
      REQ_ARRIVE:  ans.act = arrive_answer(hart, warm);
      REQ_POLL:    ans.act = poll_answer(hart);
      REQ_PUBLISH: ans.act = publish_answer(hart, quiet);
      default:     ans.act = enter_failed();
    endcase
    ans.phase = model_phase;
    ans.fault = model_fault;
    return ans;
  endfunction

  // random hart that has already arrived
  function automatic logic [HartW-1:0] pick_arrived();
    int h;
    do h = $urandom_range(WORKERS - 1); while (!model_arrived[h]);
    return h[HartW-1:0];
  endfunction

  // offer one request, wait until it is taken, then record its answer
  task automatic send_request(input logic [1:0] req, input logic [HartW-1:0] hart,
                              input logic warm, input logic quiet);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    hart_i      <= hart;
    warm_i      <= warm;
    quiescent_i <= quiet;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    answer_q.push_back(boot_answer(req, hart, warm, quiet));
    n_sent++;
  endtask

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // answer checker
  always @(posedge clk_i) begin
    answer_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_checked++;
      act_seen[action_o]++;
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected answer: action %0d phase %0d fault %0d",
                   action_o, boot_phase_o, fault_flag_o);
      end else begin
        exp = answer_q.pop_front();
        if (action_o !== exp.act || boot_phase_o !== exp.phase ||
            fault_flag_o !== exp.fault) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected action %0d phase %0d fault %0d, got %0d %0d %0d",
                     exp.act, exp.phase, exp.fault, action_o, boot_phase_o, fault_flag_o);
        end
      end
    end
  end

  // watchdog on cycles where no request moves on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: nothing accepted for %0d cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // fresh phase: worker polls wait, hart 0 arrival starts initialization
  task automatic test_cold_boot();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(REQ_ARRIVE, 6'd3, 1'b0, 1'b0);
    send_request(REQ_POLL, 6'd3, 1'b0, 1'b0);
    send_request(REQ_POLL, 6'd3, 1'b1, 1'b1);
    send_request(REQ_ARRIVE, 6'd0, 1'b0, 1'b1);
    send_request(REQ_POLL, 6'd0, 1'b0, 1'b0);
    send_request(REQ_ARRIVE, HartW'(WORKERS - 1), 1'b0, 1'b0);
    send_request(REQ_ARRIVE, 6'd5, 1'b0, 1'b1);
    send_request(REQ_POLL, HartW'(WORKERS - 1), 1'b1, 1'b0);
  endtask

  // initializing phase: random polls by arrived harts
  task automatic test_init_polls(input int count);
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    repeat (count)
      send_request(REQ_POLL, pick_arrived(), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // hart 0 publishes, then workers continue and a late arrival goes straight on
  task automatic test_publish();
    send_request(REQ_PUBLISH, 6'd0, 1'b0, 1'b1);
    send_request(REQ_POLL, 6'd3, 1'b0, 1'b0);
    send_request(REQ_ARRIVE, 6'd1, 1'b0, 1'b0);
  endtask

  // ready phase: polls by arrived harts, first arrivals of the rest
  task automatic ready_burst(input int count, input int idle_pct, input int stall_pct);
    int h;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      h = $urandom_range(WORKERS - 1);
      if (model_arrived[h])
        send_request(REQ_POLL, HartW'(h), 1'($urandom_range(1)), 1'($urandom_range(1)));
      else
        send_request(REQ_ARRIVE, HartW'(h), 1'b0, 1'($urandom_range(1)));
    end
  endtask

  task automatic test_ready_traffic();
    ready_burst(250, 0, 0);
    ready_burst(250, 71, 0);
    ready_burst(250, 0, 71);
    ready_burst(250, 14, 14);
  endtask

  // long receiver hold-off with the sender at full rate
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left = HOLD_CYCLES;
    repeat (40)
      send_request(REQ_POLL, pick_arrived(), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // a double arrival faults out of ready, then every request sees the latch
  task automatic test_fault_from_ready();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(REQ_ARRIVE, 6'd3, 1'b0, 1'b0);
    send_request(REQ_ARRIVE, 6'd2, 1'b1, 1'b0);
    send_request(REQ_POLL, 6'd63, 1'b0, 1'b0);
    send_request(REQ_ARRIVE, HartW'(WORKERS), 1'b0, 1'b0);
    send_request(REQ_PUBLISH, 6'd1, 1'b0, 1'b1);
    send_request(REQ_PUBLISH, 6'd0, 1'b0, 1'b0);
    send_request(REQ_UNUSED, 6'd0, 1'b0, 1'b1);
    send_request(REQ_POLL, 6'd40, 1'b1, 1'b1);
  endtask

  // failed phase: fully random requests
  task automatic test_failed_noise(input int count);
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    repeat (count)
      send_request(2'($urandom_range(3)), HartW'($urandom_range(63)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_cold_boot();
    test_init_polls(150);
    test_publish();
    test_ready_traffic();
    test_output_backpressure();
    test_fault_from_ready();
    test_failed_noise(350);

    // release the bus and let every answer come back
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("summary: %0d requests through fresh, initializing, ready and failed phases",
             n_sent);
    $display("answers: %0d checked, wait %0d continue %0d initialize %0d published %0d",
             n_checked, act_seen[ACT_WAIT], act_seen[ACT_CONTINUE],
             act_seen[ACT_INITIALIZE], act_seen[ACT_PUBLISHED]);
    $display("answers: fault %0d, mismatches %0d", act_seen[ACT_FAULT], mismatches);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
